// ----- src/kpc_pkg.sv -----
`default_nettype none

package kpc_pkg;

   localparam int unsigned CountWidth = 32;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_DOWN = 2'd1,
      MODE_LONG = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_SHORT = 2'd1,
      EVT_LONG  = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CSR_SHORT_THRESHOLD = 2'd0,
      CSR_LONG_THRESHOLD  = 2'd1,
      CSR_SHORT_ENABLE    = 2'd2,
      CSR_LONG_ENABLE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] short_threshold;
      logic [CountWidth-1:0] long_threshold;
      logic                  short_enable;
      logic                  long_enable;
   } cfg_type;

   localparam logic [CountWidth-1:0] ShortThresholdReset = 32'd50;
   localparam logic [CountWidth-1:0] LongThresholdReset  = 32'd3000;

endpackage

`default_nettype wire

// ----- src/kpc_if.sv -----
`default_nettype none

interface kpc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              key_level;
   logic [kpc_pkg::CountWidth-1:0]    now_count;

   modport source (output valid, output key_level, output now_count, input ready);
   modport sink   (input valid, input key_level, input now_count, output ready);
endinterface

interface kpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_event;
   logic [1:0] key_mode;

   modport source (output valid, output press_event, output key_mode, input ready);
   modport sink   (input valid, input press_event, input key_mode, output ready);
endinterface

`default_nettype wire

// ----- src/kpc_csr.sv -----
`default_nettype none

module kpc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire kpc_pkg::csr_index_type         csr_index,
   input  wire logic [kpc_pkg::CountWidth-1:0] csr_write_data,
   output kpc_pkg::cfg_type                    cfg
);

   kpc_pkg::cfg_type cfg_ff;
   kpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            kpc_pkg::CSR_SHORT_THRESHOLD: cfg_in.short_threshold = csr_write_data;
            kpc_pkg::CSR_LONG_THRESHOLD:  cfg_in.long_threshold  = csr_write_data;
            kpc_pkg::CSR_SHORT_ENABLE:    cfg_in.short_enable    = csr_write_data[0];
            kpc_pkg::CSR_LONG_ENABLE:     cfg_in.long_enable     = csr_write_data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_threshold <= kpc_pkg::ShortThresholdReset;
         cfg_ff.long_threshold  <= kpc_pkg::LongThresholdReset;
         cfg_ff.short_enable    <= 1'b1;
         cfg_ff.long_enable     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/kpc_engine.sv -----
`default_nettype none

module kpc_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kpc_pkg::cfg_type cfg,
   kpc_req_if.sink               req_chan,
   kpc_rsp_if.source             rsp_chan
);

   localparam int unsigned W = kpc_pkg::CountWidth;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_key_ff;
   logic [W-1:0]          in_now_ff;

   kpc_pkg::mode_type     mode_ff, mode_in;
   logic [W-1:0]          start_ff, start_in;
   logic                  reported_ff, reported_in;

   logic                  out_valid_ff, out_valid_in;
   kpc_pkg::event_type    out_event_ff, out_event_in;
   kpc_pkg::mode_type     out_mode_ff;

   logic                  in_ready;
   logic                  out_ready;
   logic                  step;
   logic                  pressed;
   logic [W-1:0]          start_eff;
   logic [W-1:0]          elapsed;
   logic                  at_long;
   logic                  in_short;
   logic                  long_fire;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign step      = in_valid_ff && out_ready;
   assign req_chan.ready = in_ready;

   assign pressed = (mode_ff == kpc_pkg::MODE_DOWN) || (mode_ff == kpc_pkg::MODE_LONG);

   // A press seen in idle starts its timing at this very tick.
   assign start_eff = pressed ? start_ff : (in_key_ff ? start_ff : in_now_ff);

   // When the timer has wrapped, the distance comes out one count short.
   assign elapsed   = in_now_ff - start_eff - W'(in_now_ff < start_eff);
   assign at_long   = elapsed >= cfg.long_threshold;
   assign in_short  = (elapsed >= cfg.short_threshold) && !at_long;
   assign long_fire = at_long && cfg.long_enable && !reported_ff;

   always_comb begin
      if (in_key_ff) begin
         mode_in = kpc_pkg::MODE_IDLE;
      end else begin
         unique case (mode_ff)
            kpc_pkg::MODE_LONG: mode_in = kpc_pkg::MODE_LONG;
            kpc_pkg::MODE_DOWN: mode_in = at_long ? kpc_pkg::MODE_LONG : kpc_pkg::MODE_DOWN;
            default:            mode_in = at_long ? kpc_pkg::MODE_LONG : kpc_pkg::MODE_DOWN;
         endcase
      end
   end

   always_comb begin
      start_in     = start_ff;
      reported_in  = reported_ff;
      out_event_in = kpc_pkg::EVT_NONE;
      unique case (mode_ff)
         kpc_pkg::MODE_DOWN: begin
            if (in_key_ff) begin
               start_in    = '0;
               reported_in = 1'b0;
               if (in_short && cfg.short_enable) begin
                  out_event_in = kpc_pkg::EVT_SHORT;
               end else if (at_long && cfg.long_enable) begin
                  out_event_in = kpc_pkg::EVT_LONG;
               end
            end else if (long_fire) begin
               reported_in  = 1'b1;
               out_event_in = kpc_pkg::EVT_LONG;
            end
         end
         kpc_pkg::MODE_LONG: begin
            if (in_key_ff) begin
               start_in    = '0;
               reported_in = 1'b0;
            end else if (long_fire) begin
               reported_in  = 1'b1;
               out_event_in = kpc_pkg::EVT_LONG;
            end
         end
         default: begin
            if (!in_key_ff) begin
               start_in = in_now_ff;
               if (long_fire) begin
                  reported_in  = 1'b1;
                  out_event_in = kpc_pkg::EVT_LONG;
               end
            end
         end
      endcase
   end

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !out_ready);
   assign out_valid_in = step || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= kpc_pkg::MODE_IDLE;
         start_ff     <= '0;
         reported_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_ready ? in_valid_in : in_valid_ff;
         out_valid_ff <= out_valid_in;
         if (step) begin
            mode_ff     <= mode_in;
            start_ff    <= start_in;
            reported_ff <= reported_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_key_ff <= req_chan.key_level;
         in_now_ff <= req_chan.now_count;
      end
      if (step) begin
         out_event_ff <= out_event_in;
         out_mode_ff  <= mode_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.press_event = out_event_ff;
   assign rsp_chan.key_mode    = out_mode_ff;

endmodule

`default_nettype wire

// ----- src/key_short_long_press_classifier.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_chan  in         valid / ready        key_level, now_count
// rsp_chan  out        valid / ready        press_event, key_mode
// csr_*     in         csr_write_en only    csr_index, csr_write_data
//
// Each transaction is registered at the input and then classified into the result register
// as soon as that register is free, and its result is offered from there.
// One transaction is accepted per cycle while the result is not stalled; the single subtract and two
// threshold compares between the input and result registers set that rate.
// Reset is synchronous and active high and returns the key to idle.
// A stalled result holds in its register while the input register still fills.

module key_short_long_press_classifier (
   input  wire logic                           clock,
   input  wire logic                           reset,
   kpc_req_if.sink                             req_chan,
   kpc_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write_en,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [kpc_pkg::CountWidth-1:0] csr_write_data
);

   kpc_pkg::cfg_type cfg;

   kpc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (kpc_pkg::csr_index_type'(csr_index)),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   kpc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_short_ends_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.press_event == kpc_pkg::EVT_SHORT)
      |-> (rsp_chan.key_mode == kpc_pkg::MODE_IDLE))
      else $error("Short event reported while the key is not idle.");

   a_no_event_while_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.key_mode == kpc_pkg::MODE_DOWN)
      |-> (rsp_chan.press_event == kpc_pkg::EVT_NONE))
      else $error("Event reported while the key is down below the long threshold.");

   a_long_twice_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.key_mode == kpc_pkg::MODE_LONG
       && rsp_chan.press_event == kpc_pkg::EVT_LONG && !csr_write_en)
      |=> !(rsp_chan.valid && rsp_chan.key_mode == kpc_pkg::MODE_LONG
            && rsp_chan.press_event == kpc_pkg::EVT_LONG))
      else $error("Long event repeated within one held press.");
`endif

endmodule

`default_nettype wire
